/* design/fdsu_pkg.sv */
`default_nettype none

package fdsu_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CELL_W      = 32;
  localparam int LIT_W       = 31;
  localparam int ACT_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_W     = 10;
  localparam int IDX_W       = 3;   // covers up to six cells touched by one operation
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 48;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_DROP  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_2DROP = 4'd2;
  localparam logic [ACT_W-1:0] ACT_ADD   = 4'd3;
  localparam logic [ACT_W-1:0] ACT_DUP   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_2DUP  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_QDUP  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_OVER  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_2OVER = 4'd8;
  localparam logic [ACT_W-1:0] ACT_ROT   = 4'd9;
  localparam logic [ACT_W-1:0] ACT_SWAP  = 4'd10;
  localparam logic [ACT_W-1:0] ACT_2SWAP = 4'd11;
  localparam logic [ACT_W-1:0] ACT_DOT   = 4'd12;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

  // where a written cell comes from: one of the four fetched top cells, the literal or the sum
  typedef enum logic [2:0] {
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_LIT,
    SRC_SUM
  } src_t;

  typedef struct packed {
    logic                 load_in;
    logic                 rd_en;
    logic                 cap_en;
    logic                 wr_en;
    logic                 cnt_upd;
    logic                 out_load;
    logic                 show;
    logic [STATUS_W-1:0]  status;
    logic [ACT_W-1:0]     action;
    logic [IDX_W-1:0]     idx;
  } fdsu_cmd_t;

  typedef struct packed {
    logic under;
    logic over;
    logic t0_nz;
  } fdsu_stat_t;

  // cells read from the top
  function automatic logic [IDX_W-1:0] op_need(input logic [ACT_W-1:0] act);
    logic [IDX_W-1:0] n;
    unique case (act)
      ACT_PUSH:  n = 3'd0;
      ACT_DROP:  n = 3'd1;
      ACT_2DROP: n = 3'd2;
      ACT_ADD:   n = 3'd2;
      ACT_DUP:   n = 3'd1;
      ACT_2DUP:  n = 3'd2;
      ACT_QDUP:  n = 3'd1;
      ACT_OVER:  n = 3'd2;
      ACT_2OVER: n = 3'd4;
      ACT_ROT:   n = 3'd3;
      ACT_SWAP:  n = 3'd2;
      ACT_2SWAP: n = 3'd4;
      ACT_DOT:   n = 3'd1;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // cells above the base (count - need) once the operation is done
  function automatic logic [IDX_W-1:0] op_keep(input logic [ACT_W-1:0] act,
                                               input logic             t0_nz);
    logic [IDX_W-1:0] k;
    unique case (act)
      ACT_PUSH:  k = 3'd1;
      ACT_ADD:   k = 3'd1;
      ACT_DUP:   k = 3'd2;
      ACT_2DUP:  k = 3'd4;
      ACT_QDUP:  k = t0_nz ? 3'd2 : 3'd1;
      ACT_OVER:  k = 3'd3;
      ACT_2OVER: k = 3'd6;
      ACT_ROT:   k = 3'd3;
      ACT_SWAP:  k = 3'd2;
      ACT_2SWAP: k = 3'd4;
      default:   k = 3'd0;
    endcase
    return k;
  endfunction

  // first slot above the base that gets written
  function automatic logic [IDX_W-1:0] op_wstart(input logic [ACT_W-1:0] act);
    logic [IDX_W-1:0] s;
    unique case (act)
      ACT_DUP:   s = 3'd1;
      ACT_2DUP:  s = 3'd2;
      ACT_QDUP:  s = 3'd1;
      ACT_OVER:  s = 3'd2;
      ACT_2OVER: s = 3'd4;
      default:   s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic src_t op_src(input logic [ACT_W-1:0] act,
                                  input logic [IDX_W-1:0] idx);
    src_t s;
    unique case (act)
      ACT_PUSH:  s = SRC_LIT;
      ACT_ADD:   s = SRC_SUM;
      ACT_2DUP:  s = (idx == 3'd2) ? SRC_T1 : SRC_T0;
      ACT_OVER:  s = SRC_T1;
      ACT_2OVER: s = (idx == 3'd4) ? SRC_T3 : SRC_T2;
      ACT_ROT: begin
        unique case (idx)
          3'd0:    s = SRC_T1;
          3'd1:    s = SRC_T0;
          default: s = SRC_T2;
        endcase
      end
      ACT_SWAP:  s = (idx == 3'd0) ? SRC_T0 : SRC_T1;
      ACT_2SWAP: begin
        unique case (idx)
          3'd0:    s = SRC_T1;
          3'd1:    s = SRC_T0;
          3'd2:    s = SRC_T3;
          default: s = SRC_T2;
        endcase
      end
      default:   s = SRC_T0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/fdsu_ctrl.sv */
`default_nettype none

module fdsu_ctrl
  import fdsu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TUSER_W-1:0] s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire fdsu_stat_t            stat,
  output fdsu_cmd_t                  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state, state_next;
  logic [ACT_W-1:0]    act;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [STATUS_W-1:0] status, status_next;
  logic                m_tvalid_next;
  logic [IDX_W-1:0]    need, keep, wstart;

  assign need   = op_need(act);
  assign keep   = op_keep(act, stat.t0_nz);
  assign wstart = op_wstart(act);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    status_next   = status;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.action    = act;
    cmd.idx       = idx;
    cmd.status    = status;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          idx_next    = '0;
          state_next  = S_READ;
        end
      end
      // memory read is registered: the cell addressed at idx lands in the next cycle
      S_READ: begin
        cmd.rd_en  = (idx < need) && !stat.under;
        cmd.cap_en = (idx != '0);
        if (idx == need || stat.under) begin
          state_next = S_CHECK;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      S_CHECK: begin
        if (stat.under) begin
          status_next = ST_UNDER;
          state_next  = S_DONE;
        end else if (stat.over) begin
          status_next = ST_OVER;
          state_next  = S_DONE;
        end else begin
          status_next = ST_OK;
          idx_next    = wstart;
          state_next  = S_WRITE;
        end
      end
      S_WRITE: begin
        if (idx < keep) begin
          cmd.wr_en = 1'b1;
          idx_next  = idx + 3'd1;
        end else begin
          cmd.cnt_upd = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          cmd.show     = (status == ST_OK) && (act == ACT_DOT);
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (m_tready) m_tvalid_next = 1'b0;
    if (cmd.out_load) m_tvalid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    status <= status_next;
    if (cmd.load_in) act <= s_tuser[ACT_W-1:0];
  end

endmodule

`default_nettype wire

/* design/fdsu_dpath.sv */
`default_nettype none

module fdsu_dpath
  import fdsu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire fdsu_cmd_t              cmd,
  output fdsu_stat_t                  stat,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  logic [CELL_W-1:0]   mem [STACK_DEPTH];
  logic [CELL_W-1:0]   rd_data;
  logic [CELL_W-1:0]   tc [4];
  logic [LIT_W-1:0]    literal;
  logic [PTR_W-1:0]    count;
  logic [IDX_W-1:0]    need, keep;
  logic [PTR_W-1:0]    base, rd_addr, wr_addr;
  logic [PTR_W:0]      new_top;
  logic [CELL_W-1:0]   wr_data;
  logic [1:0]          cap_idx;

  logic [STATUS_W-1:0] out_status;
  logic                out_shown_valid;
  logic [CELL_W-1:0]   out_shown_value;
  logic [DEPTH_W-1:0]  out_depth;

  assign need    = op_need(cmd.action);
  assign keep    = op_keep(cmd.action, stat.t0_nz);
  assign base    = count - PTR_W'(need);
  assign rd_addr = count - PTR_W'(cmd.idx) - PTR_W'(1);
  assign wr_addr = base + PTR_W'(cmd.idx);
  assign new_top = {1'b0, base} + (PTR_W + 1)'(keep);
  assign cap_idx = 2'(cmd.idx - 3'd1);

  assign stat.under = count < PTR_W'(need);
  assign stat.over  = new_top > (PTR_W + 1)'(STACK_DEPTH - 1);
  assign stat.t0_nz = tc[0] != '0;

  always_comb begin
    case (op_src(cmd.action, cmd.idx))
      SRC_T0:  wr_data = tc[0];
      SRC_T1:  wr_data = tc[1];
      SRC_T2:  wr_data = tc[2];
      SRC_T3:  wr_data = tc[3];
      SRC_LIT: wr_data = {1'b0, literal};
      SRC_SUM: wr_data = tc[0] + tc[1];
      default: wr_data = tc[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_upd) begin
      count <= new_top[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) literal <= s_tdata[LIT_W-1:0];
    if (cmd.cap_en) tc[cap_idx] <= rd_data;
    if (cmd.out_load) begin
      out_status      <= cmd.status;
      out_shown_valid <= cmd.show;
      out_shown_value <= cmd.show ? tc[0] : '0;
      out_depth       <= DEPTH_W'(count);
    end
  end

  assign m_tdata = {3'b000, out_depth, out_shown_value, out_shown_valid, out_status};

endmodule

`default_nettype wire

/* design/forth_data_stack_unit.sv */
`default_nettype none
// Forth data stack: each input beat carries one stack operation (push, drop, 2drop, add,
// dup, 2dup, ?dup, over, 2over, rot, swap, 2swap, dot) and yields exactly one output beat
// with the status, the value shown by dot and the depth after the operation. The stack
// lives in a RAM of STACK_DEPTH 32-bit cells and holds at most STACK_DEPTH-1
// of them; underflow and overflow are reported and leave the stack as it was. Operations
// run one at a time: an operation that passes its checks fetches R cells from the top
// (0 to 4) and then writes back W cells (0 to 4), since the RAM is read and written one
// cell at a time. Nothing is written back on a failed check: an underflow stops the
// fetches, and an overflow is found after them. The output beat may wait for m_tready.
// No clearing pass is needed after reset.

module forth_data_stack_unit
  import fdsu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [30:0] literal, [31] zero
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // [3:0] action
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata    // [1:0] status, [2] shown_valid,
                                                 // [34:3] shown_value, [44:35] depth
);

  fdsu_cmd_t  cmd;
  fdsu_stat_t stat;

  fdsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdsu_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata)
  );

endmodule

`default_nettype wire
